/* src/rdrc_pkg.sv */
`timescale 1ns / 1ps

package rdrc_pkg;

  localparam int SLOT_W   = 3;
  localparam int STATUS_W = 31;
  localparam int LEN_W    = 14;
  localparam int BSIZE_W  = 12;
  localparam int PAD_W    = 4;
  localparam int OFFS_W   = 15;
  localparam int CFG_W    = 14;

  localparam logic MODE_COMPLETE = 1'b0;
  localparam logic MODE_POLL     = 1'b1;

  // Receive status word layout.
  localparam int FL_LSB = 16;
  localparam int FL_MSB = 29;
  localparam int ES_BIT = 15;
  localparam int DE_BIT = 14;
  localparam int LE_BIT = 12;
  localparam int FS_BIT = 9;
  localparam int LS_BIT = 8;
  localparam int FT_BIT = 5;

  localparam logic [LEN_W-1:0] CRC_BYTES = 14'd4;

  typedef enum logic [2:0] {
    VERDICT_OK      = 3'd0,
    VERDICT_SEGMENT = 3'd1,
    VERDICT_ERROR   = 3'd2,
    VERDICT_RANGE   = 3'd3,
    VERDICT_LENGTH  = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    CFG_MIN_LEN  = 2'd0,
    CFG_MAX_LEN  = 2'd1,
    CFG_BUF_SIZE = 2'd2,
    CFG_HDR_PAD  = 2'd3
  } cfg_reg_t;

  // Ownership updates from the datapath to the scanner.
  typedef struct packed {
    logic clr;
    logic set;
  } scan_cmd_t;

endpackage

/* src/rdrc_status_ram.sv */
`timescale 1ns / 1ps

module rdrc_status_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 31
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/rdrc_scan.sv */
`timescale 1ns / 1ps

module rdrc_scan import rdrc_pkg::*; #(
  parameter int SLOTS = 8,
  parameter int IW    = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scan_cmd_t     cmd,
  input  logic [IW-1:0] clr_idx,
  input  logic [IW-1:0] set_idx,
  output logic          hit,
  output logic [IW-1:0] idx
);

  logic [SLOTS-1:0] owned_r, owned_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;
  logic [SLOTS-1:0] free, upper, pick, first;

  // Rotating priority: free slots at or above the current slot win,
  // otherwise the lowest free slot overall.
  always_comb begin
    free = ~owned_r;
    for (int i = 0; i < SLOTS; i++) begin
      upper[i] = free[i] && (IW'(i) >= cur_r);
    end
    pick  = (|upper) ? upper : free;
    first = pick & (~pick + SLOTS'(1));
    idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (first[i]) begin
        idx = idx | IW'(i);
      end
    end
    hit = |free;
  end

  always_comb begin
    owned_nxt = owned_r;
    cur_nxt   = cur_r;
    if (cmd.clr) begin
      owned_nxt[clr_idx] = 1'b0;
    end
    if (cmd.set) begin
      owned_nxt[set_idx] = 1'b1;
      cur_nxt = (set_idx == IW'(SLOTS - 1)) ? '0 : set_idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owned_r <= '1;
      cur_r   <= '0;
    end else begin
      owned_r <= owned_nxt;
      cur_r   <= cur_nxt;
    end
  end

  a_set_owns: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set |=> owned_r[$past(set_idx)])
    else $error("returned slot is not owned by DMA");

  a_hit_free: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> !owned_r[idx])
    else $error("scan picked a slot owned by DMA");

  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= IW'(SLOTS - 1))
    else $error("current slot outside the ring");

endmodule

/* src/rdrc_classify.sv */
`timescale 1ns / 1ps

module rdrc_classify import rdrc_pkg::*; (
  input  logic                hit,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [STATUS_W-1:0] status,
  input  logic [LEN_W-1:0]    min_len,
  input  logic [LEN_W-1:0]    max_len,
  input  logic [BSIZE_W-1:0]  buf_size,
  input  logic [PAD_W-1:0]    hdr_pad,
  output verdict_t            verdict,
  output logic [LEN_W-1:0]    payload_len,
  output logic [OFFS_W-1:0]   buffer_offset
);

  logic [LEN_W-1:0]  flen;
  logic [OFFS_W-1:0] prod;

  always_comb begin
    flen        = status[FL_MSB:FL_LSB];
    verdict     = VERDICT_OK;
    payload_len = '0;
    prod        = OFFS_W'(slot) * OFFS_W'(buf_size);
    if (!hit) begin
      buffer_offset = '0;
    end else begin
      buffer_offset = prod + OFFS_W'(hdr_pad);
      priority if (!status[FS_BIT] || !status[LS_BIT]) begin
        verdict = VERDICT_SEGMENT;
      end else if (status[ES_BIT] || status[DE_BIT]) begin
        verdict = VERDICT_ERROR;
      end else if (flen < min_len || flen > max_len) begin
        verdict = VERDICT_RANGE;
      end else if (status[LE_BIT] && !status[FT_BIT]) begin
        verdict = VERDICT_LENGTH;
      end else begin
        payload_len = (flen >= CRC_BYTES) ? flen - CRC_BYTES : '0;
      end
    end
  end

endmodule

/* src/rx_descriptor_ring_consumer.sv */
`timescale 1ns / 1ps
// Receive descriptor ring, consumer side.
// Input beats on in_*: tuser selects completion (DMA finished a slot, the
// status word is stored and the slot goes to software) or poll (find the
// next slot owned by software, starting at the current slot).
// A completion gives no output beat. A poll first does the rotating
// priority search over the owned bits plus the status RAM read, then
// classifies the status and computes the buffer offset. Its single
// result beat is registered on out_*, and in_tready stays low while
// the poll is in flight, so a new beat waits until the poll is through.
// Configuration writes on cfg_* are always taken and must only be issued
// while the block is idle.
// Reset marks every slot as owned by DMA and zeroes the current slot; the
// status RAM needs no clearing, since a slot is read only after a
// completion wrote it. If the receiver stalls, the result holds in the
// output register and no new beat is accepted until it drains.
module rx_descriptor_ring_consumer import rdrc_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] slot, [34:3] status_word, [39:35] zero
  input  logic [39:0] in_tdata,
  // [0] mode
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] slot_index, [16:3] payload_len, [31:17] buffer_offset
  output logic [31:0] out_tdata,
  // [0] found, [3:1] verdict
  output logic [3:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [LEN_W-1:0]   min_len_r, max_len_r;
  logic [BSIZE_W-1:0] buf_size_r;
  logic [PAD_W-1:0]   hdr_pad_r;

  logic               accept, poll_acc, comp_acc;
  logic [IW+2:0]      slot_ext;
  logic               slot_ok;
  logic               pend_r, pend_nxt;
  logic               hit_r;
  logic [IW-1:0]      idx_r;
  logic [IW+2:0]      idx_ext;

  scan_cmd_t          cmd;
  logic               scan_hit;
  logic [IW-1:0]      scan_idx;
  logic [STATUS_W-1:0] rd_status;

  verdict_t           verdict;
  logic [LEN_W-1:0]   payload_len;
  logic [OFFS_W-1:0]  buffer_offset;

  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r;
  verdict_t           out_verdict_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [LEN_W-1:0]   out_len_r;
  logic [OFFS_W-1:0]  out_offs_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r  <= 14'd64;
      max_len_r  <= 14'd1518;
      buf_size_r <= 12'd1536;
      hdr_pad_r  <= 4'd2;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MIN_LEN:  min_len_r  <= cfg_data;
        CFG_MAX_LEN:  max_len_r  <= cfg_data;
        CFG_BUF_SIZE: buf_size_r <= cfg_data[BSIZE_W-1:0];
        CFG_HDR_PAD:  hdr_pad_r  <= cfg_data[PAD_W-1:0];
      endcase
    end
  end

  // A new beat waits for the poll in flight and for room in the output.
  assign in_tready = !pend_r && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign slot_ext  = (IW + 3)'(in_tdata[2:0]);
  assign slot_ok   = slot_ext < (IW + 3)'(SLOTS);
  assign poll_acc  = accept && (in_tuser[0] == MODE_POLL);
  assign comp_acc  = accept && (in_tuser[0] == MODE_COMPLETE) && slot_ok;

  assign cmd.clr = comp_acc;
  assign cmd.set = pend_r && hit_r;

  rdrc_scan #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .clr_idx (slot_ext[IW-1:0]),
    .set_idx (idx_r),
    .hit     (scan_hit),
    .idx     (scan_idx)
  );

  // Owner bit 31 is dropped before the status is stored.
  rdrc_status_ram #(
    .DEPTH (SLOTS),
    .AW    (IW),
    .DW    (STATUS_W)
  ) u_ram (
    .clk   (clk),
    .we    (comp_acc),
    .waddr (slot_ext[IW-1:0]),
    .wdata (in_tdata[33:3]),
    .re    (poll_acc),
    .raddr (scan_idx),
    .rdata (rd_status)
  );

  assign pend_nxt = poll_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_acc) begin
      hit_r <= scan_hit;
      idx_r <= scan_idx;
    end
  end

  assign idx_ext = (IW + 3)'(idx_r);

  rdrc_classify u_classify (
    .hit           (hit_r),
    .slot          (idx_ext[2:0]),
    .status        (rd_status),
    .min_len       (min_len_r),
    .max_len       (max_len_r),
    .buf_size      (buf_size_r),
    .hdr_pad       (hdr_pad_r),
    .verdict       (verdict),
    .payload_len   (payload_len),
    .buffer_offset (buffer_offset)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pend_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      out_found_r   <= hit_r;
      out_verdict_r <= verdict;
      out_slot_r    <= hit_r ? idx_ext[2:0] : '0;
      out_len_r     <= payload_len;
      out_offs_r    <= buffer_offset;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_offs_r, out_len_r, out_slot_r};
  assign out_tuser  = {out_verdict_r, out_found_r};

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !in_tready)
    else $error("input accepted while a poll is in flight");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !out_valid_r)
    else $error("poll retires into an occupied output register");

  a_poll_result: assert property (@(posedge clk) disable iff (!rst_n)
    poll_acc |=> ##1 out_valid_r)
    else $error("poll gave no result beat");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_tdata == 32'd0 && out_tuser == 4'd0)
    else $error("empty poll result is not all zero");

endmodule
